[sv/quad_square_test_assert.svh]
// assertion macros for the near-square test block
// used by quad_square_test.sv; expects i_clk and i_rst_n in scope
`ifndef QUAD_SQUARE_TEST_ASSERT_SVH
`define QUAD_SQUARE_TEST_ASSERT_SVH

// checked outside reset
`define QST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define QST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/qst_pkg.sv]
// shared constants and types for the near-square test pipeline
// no dependencies
`default_nettype none

package qst_pkg;

    localparam int FIELD_W     = 12;
    localparam int COORD_BITS  = 12;
    localparam int SLACK_W     = 16;
    localparam int FRAC_BITS   = 12;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_SIDES   = 4;
    localparam int NUM_LEN     = 6;
    localparam int DIAG_A      = 4;
    localparam int DIAG_B      = 5;

    localparam int SQ_W     = 2 * COORD_BITS + 1;
    localparam int K_W      = SLACK_W + 1;
    localparam int K2_W     = 2 * K_W;
    localparam int K2_LO_W  = 16;
    localparam int K2_HI_W  = K2_W - K2_LO_W;
    localparam int PH_W     = K2_HI_W + SQ_W;
    localparam int PL_W     = K2_LO_W + SQ_W;
    localparam int PROD_W   = K2_W + SQ_W;
    localparam int LHS_W    = SQ_W + 2 * FRAC_BITS;
    localparam int CMP_W    = (PROD_W > LHS_W) ? PROD_W : LHS_W;

    localparam int MIN_SIDE_SQ = 100;
    localparam int ONE_Q       = 1 << FRAC_BITS;

    // endpoints of each measured length: four sides, then the two diagonals
    localparam int PAIR_A [NUM_LEN] = '{0, 1, 2, 3, 0, 1};
    localparam int PAIR_B [NUM_LEN] = '{1, 2, 3, 0, 2, 3};

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_corner;

    typedef logic [SQ_W-1:0] t_len;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

`default_nettype wire

[sv/qst_dist.sv]
// stages one and two: coordinate differences, then squared lengths
// depends on qst_pkg
`default_nettype none

module qst_dist
    import qst_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire t_pipe_en                  i_en,
    input  wire t_corner [NUM_CORNERS-1:0] i_corner,
    output t_len                           o_len [NUM_LEN-1:0]
);

    logic [COORD_BITS-1:0] r_dx [NUM_LEN];
    logic [COORD_BITS-1:0] r_dy [NUM_LEN];
    t_len                  r_len [NUM_LEN];

    for (genvar j = 0; j < NUM_LEN; j++) begin : g_len
        logic [COORD_BITS-1:0] n_dx;
        logic [COORD_BITS-1:0] n_dy;
        logic [2*COORD_BITS-1:0] w_sx;
        logic [2*COORD_BITS-1:0] w_sy;
        t_corner w_a;
        t_corner w_b;

        assign w_a  = i_corner[PAIR_A[j]];
        assign w_b  = i_corner[PAIR_B[j]];
        assign n_dx = (w_a.x > w_b.x) ? w_a.x - w_b.x : w_b.x - w_a.x;
        assign n_dy = (w_a.y > w_b.y) ? w_a.y - w_b.y : w_b.y - w_a.y;
        assign w_sx = (2*COORD_BITS)'(r_dx[j]) * (2*COORD_BITS)'(r_dx[j]);
        assign w_sy = (2*COORD_BITS)'(r_dy[j]) * (2*COORD_BITS)'(r_dy[j]);

        always_ff @(posedge i_clk) begin
            if (i_en.s1) begin
                r_dx[j] <= n_dx;
                r_dy[j] <= n_dy;
            end
            if (i_en.s2) begin
                r_len[j] <= SQ_W'(w_sx) + SQ_W'(w_sy);
            end
        end

        assign o_len[j] = r_len[j];
    end

endmodule

`default_nettype wire

[sv/qst_ratio.sv]
// stages three and four: scaled lengths in partial products, then ratio tests
// depends on qst_pkg
`default_nettype none

module qst_ratio
    import qst_pkg::*;
(
    input  wire logic            i_clk,
    input  wire t_pipe_en        i_en,
    input  wire logic [K2_W-1:0] i_k2,
    input  wire t_len            i_len [NUM_LEN-1:0],
    output logic                 o_is_square
);

    logic [PH_W-1:0]  r_ph   [NUM_LEN];
    logic [PL_W-1:0]  r_pl   [NUM_LEN];
    t_len             r_len3 [NUM_LEN];
    logic [NUM_SIDES-1:0] r_long;
    logic             r_is_square;

    logic [CMP_W-1:0] w_prod [NUM_LEN];
    logic [CMP_W-1:0] w_lhs  [NUM_LEN];
    logic [NUM_SIDES-1:0] w_side_bad;
    logic             w_diag_bad;
    logic             n_is_square;

    for (genvar j = 0; j < NUM_LEN; j++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (i_en.s3) begin
                r_ph[j]   <= PH_W'(i_k2[K2_W-1:K2_LO_W]) * PH_W'(i_len[j]);
                r_pl[j]   <= PL_W'(i_k2[K2_LO_W-1:0]) * PL_W'(i_len[j]);
                r_len3[j] <= i_len[j];
            end
        end

        // length squared in the same q.24 scale as k squared
        assign w_prod[j] = (CMP_W'(r_ph[j]) << K2_LO_W) + CMP_W'(r_pl[j]);
        assign w_lhs[j]  = CMP_W'(r_len3[j]) << (2 * FRAC_BITS);
    end

    for (genvar i = 0; i < NUM_SIDES; i++) begin : g_side
        localparam int NXT = (i + 1) % NUM_SIDES;

        always_ff @(posedge i_clk) begin
            if (i_en.s3) begin
                r_long[i] <= i_len[i] > SQ_W'(MIN_SIDE_SQ);
            end
        end

        assign w_side_bad[i] = (w_lhs[i] > w_prod[NXT]) || (w_lhs[NXT] > w_prod[i]);
    end

    assign w_diag_bad = (w_lhs[DIAG_A] > w_prod[DIAG_B]) || (w_lhs[DIAG_B] > w_prod[DIAG_A]);
    assign n_is_square = (&r_long) && !(|w_side_bad) && !w_diag_bad;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_is_square <= n_is_square;
        end
    end

    assign o_is_square = r_is_square;

endmodule

`default_nettype wire

[sv/quad_square_test.sv]
// near-square test for a quadrilateral, top level with pipeline control
// depends on qst_pkg, qst_dist, qst_ratio and quad_square_test_assert.svh
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     i_corner0_x .. i_corner3_y
//  result    out        o_out_valid / i_out_ready   o_is_square
//  config    in         i_cfg_we                    i_cfg_wdata (ratio_slack)
//
// one item a cycle unless i_out_ready is low with every stage full
// four register stages: differences, squares, partial products, ratio tests
// each stage holds its item until the next one is free, bubbles close up
// reset clears the valid bits and the slack register and sets the squared factor to one; payload is not reset
// a config write reaches the slack register first, then the squared factor r_k2
`default_nettype none
`include "quad_square_test_assert.svh"

module quad_square_test
    import qst_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [FIELD_W-1:0] i_corner0_x,
    input  wire logic [FIELD_W-1:0] i_corner0_y,
    input  wire logic [FIELD_W-1:0] i_corner1_x,
    input  wire logic [FIELD_W-1:0] i_corner1_y,
    input  wire logic [FIELD_W-1:0] i_corner2_x,
    input  wire logic [FIELD_W-1:0] i_corner2_y,
    input  wire logic [FIELD_W-1:0] i_corner3_x,
    input  wire logic [FIELD_W-1:0] i_corner3_y,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_is_square,
    input  wire logic               i_cfg_we,
    input  wire logic [SLACK_W-1:0] i_cfg_wdata
);

    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_v4;
    logic [SLACK_W-1:0] r_ratio_slack;
    logic [K2_W-1:0]    r_k2;
    logic [K_W-1:0]     n_k;

    t_pipe_en                  w_en;
    t_corner [NUM_CORNERS-1:0] w_corner;
    t_len                      w_len [NUM_LEN-1:0];

    // stage advance: free or moving on
    assign w_en.s4 = !r_v4 || i_out_ready;
    assign w_en.s3 = !r_v3 || w_en.s4;
    assign w_en.s2 = !r_v2 || w_en.s3;
    assign w_en.s1 = !r_v1 || w_en.s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en.s1) begin
                r_v1 <= i_in_valid;
            end
            if (w_en.s2) begin
                r_v2 <= r_v1;
            end
            if (w_en.s3) begin
                r_v3 <= r_v2;
            end
            if (w_en.s4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign n_k = K_W'(ONE_Q) + K_W'(r_ratio_slack);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_slack <= '0;
            r_k2          <= K2_W'(ONE_Q) * K2_W'(ONE_Q);
        end else begin
            if (i_cfg_we) begin
                r_ratio_slack <= i_cfg_wdata;
            end
            r_k2 <= K2_W'(n_k) * K2_W'(n_k);
        end
    end

    assign w_corner[0] = '{x: i_corner0_x[COORD_BITS-1:0], y: i_corner0_y[COORD_BITS-1:0]};
    assign w_corner[1] = '{x: i_corner1_x[COORD_BITS-1:0], y: i_corner1_y[COORD_BITS-1:0]};
    assign w_corner[2] = '{x: i_corner2_x[COORD_BITS-1:0], y: i_corner2_y[COORD_BITS-1:0]};
    assign w_corner[3] = '{x: i_corner3_x[COORD_BITS-1:0], y: i_corner3_y[COORD_BITS-1:0]};

    qst_dist u_dist (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_corner (w_corner),
        .o_len    (w_len)
    );

    qst_ratio u_ratio (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_k2        (r_k2),
        .i_len       (w_len),
        .o_is_square (o_is_square)
    );

    assign o_in_ready  = w_en.s1;
    assign o_out_valid = r_v4;

    `QST_ASSERT(a_full_when_blocked, !o_in_ready |-> (r_v1 && r_v2 && r_v3 && r_v4), "input blocked with a free stage")
    `QST_ASSERT(a_stalled_item_kept, (r_v3 && !w_en.s3) |=> r_v3, "stalled item dropped from stage three")
    `QST_ASSERT(a_transfer_enters, (i_in_valid && o_in_ready) |=> r_v1, "transfer not captured in stage one")
    `QST_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> (!r_v1 && !r_v4), "pipeline not empty after reset")

endmodule

`default_nettype wire
